@@ design/edge_flag_edge_rasterizer_assert.svh @@
// Assertion macros shared by the edge rasterizer modules.
// Each module that asserts has a clock named i_clk and an active-low reset i_rst_n.
`ifndef EDGE_FLAG_EDGE_RASTERIZER_ASSERT_SVH
`define EDGE_FLAG_EDGE_RASTERIZER_ASSERT_SVH

// Same-cycle implication.
`define EFR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define EFR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/efr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package efr_pkg;

    localparam int COORD_W     = 15;
    localparam int PIX_W       = 12;
    localparam int ROW_W       = 16;
    localparam int X_W         = 18;
    localparam int DIV_W       = 32;
    localparam int DIV_CNT_W   = $clog2(DIV_W);
    localparam int DEN_W       = 20;
    localparam int DEF_MAX_RUN = 64;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [0:0] REG_AA_MODE = 1'b0;

    typedef struct packed {
        logic [COORD_W-1:0] ax;
        logic [COORD_W-1:0] ay;
        logic [COORD_W-1:0] bx;
        logic [COORD_W-1:0] by;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
        logic [2:0]       flag_bit;
        logic             last;
        logic             clipped;
    } t_out_item;

    typedef struct packed {
        logic in_ready;
        logic set1;
        logic set2;
        logic set3;
        logic div_start;
        logic div_sel;
        logic walk;
    } t_cmd;

    typedef struct packed {
        logic no_rows;
        logic div_done;
        logic emit_last;
    } t_sts;

    // Subpixel column offset applied to each of the eight subrows.
    function automatic logic [2:0] jitter(input logic [2:0] sub);
        logic [2:0] res;
        case (sub)
            3'd0:    res = 3'd2;
            3'd1:    res = 3'd7;
            3'd2:    res = 3'd4;
            3'd3:    res = 3'd1;
            3'd4:    res = 3'd6;
            3'd5:    res = 3'd3;
            3'd6:    res = 3'd0;
            default: res = 3'd5;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

@@ design/efr_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "edge_flag_edge_rasterizer_assert.svh"

module efr_div
    import efr_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic signed [DIV_W-1:0] i_num,
    input  wire logic [DEN_W-1:0]        i_den,
    output logic                         o_done,
    output logic signed [DIV_W-1:0]      o_quo,
    output logic [DEN_W-1:0]             o_rem
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_neg;
    logic [DEN_W-1:0]     r_den;
    logic [DEN_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_quo;

    logic [DEN_W:0]       rem_sh;
    logic [DEN_W:0]       rem_diff;
    logic                 ge;
    logic [DIV_W-1:0]     mag;
    logic                 rem_nz;

    // The quotient register starts with the dividend magnitude; its top bit
    // shifts into the partial remainder while quotient bits fill from below.
    assign mag      = i_num[DIV_W-1] ? (~i_num + DIV_W'(1)) : i_num;
    assign rem_sh   = {r_rem, r_quo[DIV_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_den};
    assign ge       = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[DIV_W-1];
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= mag;
        end else if (r_busy) begin
            r_rem <= ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], ge};
        end
    end

    // Floor correction for a negative dividend: the remainder is kept non-negative.
    assign rem_nz = (r_rem != '0);
    assign o_done = r_done;
    assign o_quo  = !r_neg ? r_quo : (rem_nz ? ~r_quo : (~r_quo + DIV_W'(1)));
    assign o_rem  = (r_neg && rem_nz) ? (r_den - r_rem) : r_rem;

    `EFR_ASSERT_IMP(a_start_idle, i_start, !r_busy, "divider started while busy")
    `EFR_ASSERT_NXT(a_start_busy, i_start, r_busy, "divider did not start")
    `EFR_ASSERT_IMP(a_rem_range, o_done, (!r_busy) && (o_rem < r_den), "remainder out of range")

endmodule

`default_nettype wire

@@ design/efr_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module efr_dp
    import efr_pkg::*;
#(
    parameter int MAX_RUN = DEF_MAX_RUN
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_aa_mode,
    input  wire t_cmd      i_cmd,
    input  wire logic      i_in_valid,
    input  wire t_in_item  i_in_item,
    input  wire logic      i_out_ready,
    output logic           o_out_valid,
    output t_out_item      o_out_item,
    output t_sts           o_sts
);

    localparam int CNT_W = $clog2(MAX_RUN + 1);
    localparam int P1_W  = 21;
    localparam int P2_W  = 2 * COORD_W;

    // Sorted endpoints and mode of the edge in flight.
    logic                     r_aa;
    logic [COORD_W-1:0]       r_tx, r_ty, r_ex, r_ey;

    // Edge set-up.
    logic [ROW_W-1:0]         r_row, r_erow;
    logic [COORD_W-1:0]       r_dn;
    logic signed [COORD_W:0]  r_dm;
    logic [3:0]               r_off;
    logic [DEN_W-1:0]         r_den;
    logic signed [P1_W-1:0]   r_p1;
    logic [P2_W-1:0]          r_p2;
    logic signed [DIV_W-1:0]  r_num;
    logic [CNT_W-1:0]         r_left;
    logic                     r_clip;

    // Walker.
    logic signed [X_W-1:0]    r_x, r_xstep;
    logic [DEN_W-1:0]         r_err, r_rstep;

    logic                     r_out_valid;
    t_out_item                r_out_item;

    logic                     accept;
    logic                     b_top;
    logic [ROW_W-1:0]         ty_up, ey_up, height;
    logic                     div_done;
    logic signed [DIV_W-1:0]  div_quo;
    logic [DEN_W-1:0]         div_rem;
    logic signed [DIV_W-1:0]  div_num;
    logic [DEN_W-1:0]         div_den;
    logic                     emit;
    logic [DEN_W:0]           err_sum;
    logic                     wrap;
    logic [2:0]               sub;
    logic [X_W-1:0]           xj;
    t_out_item                item_c;

    assign accept = i_cmd.in_ready && i_in_valid;
    // On equal y the first endpoint stays on top.
    assign b_top  = i_in_item.ay > i_in_item.by;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_aa <= i_aa_mode;
            r_tx <= b_top ? i_in_item.bx : i_in_item.ax;
            r_ty <= b_top ? i_in_item.by : i_in_item.ay;
            r_ex <= b_top ? i_in_item.ax : i_in_item.bx;
            r_ey <= b_top ? i_in_item.ay : i_in_item.by;
        end
    end

    // Row ceilings at scale 2 (antialiased) or 16 (black and white).
    always_comb begin
        if (r_aa) begin
            ty_up = ({1'b0, r_ty} + ROW_W'(1)) >> 1;
            ey_up = ({1'b0, r_ey} + ROW_W'(1)) >> 1;
        end else begin
            ty_up = ({1'b0, r_ty} + ROW_W'(15)) >> 4;
            ey_up = ({1'b0, r_ey} + ROW_W'(15)) >> 4;
        end
    end

    assign height = r_erow - r_row;

    assign emit    = i_cmd.walk && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (i_cmd.set1) begin
            r_row  <= ty_up;
            r_erow <= ey_up;
            r_dn   <= r_ey - r_ty;
            r_dm   <= $signed({1'b0, r_ex}) - $signed({1'b0, r_tx});
            // Distance from the top endpoint down to the first sampled row.
            r_off  <= r_aa ? {3'b000, r_ty[0]} : (4'd0 - r_ty[3:0]);
        end else if (emit) begin
            r_row  <= r_row + ROW_W'(1);
        end
        if (i_cmd.set2) begin
            r_den  <= r_aa ? {4'b0000, r_dn, 1'b0} : {1'b0, r_dn, 4'b0000};
            r_p1   <= P1_W'(r_dm) * $signed({{(P1_W - 4){1'b0}}, r_off});
            r_p2   <= r_dn * r_tx;
            r_clip <= height > ROW_W'(MAX_RUN);
            r_left <= (height > ROW_W'(MAX_RUN)) ? CNT_W'(MAX_RUN) : height[CNT_W-1:0];
        end else if (emit) begin
            r_left <= r_left - CNT_W'(1);
        end
        if (i_cmd.set3) begin
            r_num <= {{(DIV_W - P1_W){r_p1[P1_W-1]}}, r_p1}
                   + {{(DIV_W - P2_W){1'b0}}, r_p2}
                   + {{(DIV_W - DEN_W){1'b0}}, r_den}
                   - DIV_W'(1);
        end
    end

    // The first division gives the start column, the second the per-row step.
    assign div_num = i_cmd.div_sel ? {{(DIV_W - COORD_W - 1){r_dm[COORD_W]}}, r_dm} : r_num;
    assign div_den = i_cmd.div_sel ? {{(DEN_W - COORD_W){1'b0}}, r_dn} : r_den;

    efr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    assign err_sum = {1'b0, r_err} + {1'b0, r_rstep};
    assign wrap    = err_sum >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (div_done && !i_cmd.div_sel) begin
            r_x   <= div_quo[X_W-1:0];
            r_err <= div_rem;
        end else if (emit) begin
            r_x   <= r_x + r_xstep + {{(X_W - 1){1'b0}}, wrap};
            r_err <= wrap ? err_sum[DEN_W-1:0] - r_den : err_sum[DEN_W-1:0];
        end
        if (div_done && i_cmd.div_sel) begin
            r_xstep <= div_quo[X_W-1:0];
            // The step remainder is scaled back to the row denominator.
            r_rstep <= r_aa ? {div_rem[DEN_W-2:0], 1'b0} : {div_rem[DEN_W-5:0], 4'b0000};
        end
    end

    assign sub = r_row[2:0];
    assign xj  = r_x + {{(X_W - 3){1'b0}}, jitter(sub)};

    always_comb begin
        if (r_aa) begin
            item_c.pixel_x  = xj[PIX_W+2:3];
            item_c.pixel_y  = r_row[PIX_W+2:3];
            item_c.flag_bit = sub;
        end else begin
            item_c.pixel_x  = r_x[PIX_W-1:0];
            item_c.pixel_y  = r_row[PIX_W-1:0];
            item_c.flag_bit = r_x[2:0];
        end
        item_c.last    = (r_left == CNT_W'(1));
        item_c.clipped = r_clip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_item <= item_c;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_item      = r_out_item;
    assign o_sts.no_rows   = (r_erow == r_row);
    assign o_sts.div_done  = div_done;
    assign o_sts.emit_last = emit && (r_left == CNT_W'(1));

endmodule

`default_nettype wire

@@ design/efr_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "edge_flag_edge_rasterizer_assert.svh"

module efr_ctrl
    import efr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SET1,
        S_SET2,
        S_SET3,
        S_DIV1,
        S_DIV2,
        S_WALK
    } t_state;

    t_state r_state, n_state;
    t_cmd   r_cmd, n_cmd;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_SET1;
            end
            S_SET1: n_state = S_SET2;
            // An edge that starts and ends in the same row gives no results.
            S_SET2: n_state = i_sts.no_rows ? S_IDLE : S_SET3;
            S_SET3: n_state = S_DIV1;
            S_DIV1: begin
                if (i_sts.div_done) n_state = S_DIV2;
            end
            S_DIV2: begin
                if (i_sts.div_done) n_state = S_WALK;
            end
            S_WALK: begin
                if (i_sts.emit_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        // Commands are registered, so they are derived from the next state.
        n_cmd.in_ready  = (n_state == S_IDLE);
        n_cmd.set1      = (n_state == S_SET1);
        n_cmd.set2      = (n_state == S_SET2);
        n_cmd.set3      = (n_state == S_SET3);
        n_cmd.div_start = (n_state == S_DIV1 && r_state != S_DIV1)
                       || (n_state == S_DIV2 && r_state != S_DIV2);
        n_cmd.div_sel   = (n_state == S_DIV2);
        n_cmd.walk      = (n_state == S_WALK);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cmd   <= t_cmd'{in_ready: 1'b1, default: 1'b0};
        end else begin
            r_state <= n_state;
            r_cmd   <= n_cmd;
        end
    end

    assign o_cmd = r_cmd;

    `EFR_ASSERT_IMP(a_cmd_excl, 1'b1, $onehot0({r_cmd.in_ready, r_cmd.set1, r_cmd.set2, r_cmd.set3, r_cmd.walk}), "conflicting commands")
    `EFR_ASSERT_IMP(a_div_state, i_sts.div_done, (r_state == S_DIV1) || (r_state == S_DIV2), "division finished outside a division state")
    `EFR_ASSERT_NXT(a_last_idle, i_sts.emit_last, r_cmd.in_ready && !r_cmd.walk, "walker did not stop after the last row")

endmodule

`default_nettype wire

@@ design/edge_flag_edge_rasterizer.sv @@
// Edge-flag rasterizer front end. Each input item is one polygon edge (two endpoints in
// 11.4 fixed point); the block sorts the endpoints by y, sets up the edge and emits one
// result per scanline crossed, giving the flag-buffer column, row and bit to toggle, with
// last set on the final crossing and clipped set on every crossing of an edge cut to
// MAX_RUN rows. The aa_mode register (byte address 0) selects black-and-white pixel rows
// or antialiased eighth-pixel rows with jittered offsets; it is sampled when an edge is
// accepted. Set-up steps through states SET1, SET2 and SET3 and two passes through a
// 32-step serial divider (start column, then per-row step), followed by one result per
// cycle while the output is taken; an edge that crosses no row goes idle after SET2.
// One edge is processed at a time, and the next edge is accepted while its last result
// still waits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module edge_flag_edge_rasterizer
    import efr_pkg::*;
#(
    parameter int MAX_RUN = DEF_MAX_RUN
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire t_in_item           i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output t_out_item               o_out_item,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready
);

    logic r_aa_mode;
    t_cmd cmd;
    t_sts sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aa_mode <= 1'b0;
        end else if (psel && penable && pwrite && paddr[2] == REG_AA_MODE) begin
            r_aa_mode <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_AA_MODE) ? {{(PDATA_W - 1){1'b0}}, r_aa_mode} : '0;

    efr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    efr_dp #(
        .MAX_RUN (MAX_RUN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_aa_mode   (r_aa_mode),
        .i_cmd       (cmd),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .o_sts       (sts)
    );

    assign o_in_ready = cmd.in_ready;

endmodule

`default_nettype wire
